FILE: rtl/core/spp_pkg.sv
// Shared types and constants for the sweep and prune pair finder.
// Depends on nothing; every file but spp_if imports it.
package spp_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int OBJ_W       = 6;
	localparam int SIZE_W      = 7;
	localparam int ROW_W       = 2 * MAX_OBJECTS;
	localparam int TOTAL_W     = 11;

	// configuration register indexes
	localparam logic [1:0] REG_OBJECT_COUNT    = 2'd0;
	localparam logic [1:0] REG_DIMENSION_COUNT = 2'd1;
	localparam logic [1:0] REG_USE_SETS        = 2'd2;
	localparam logic [1:0] REG_SET_MODE        = 2'd3;

	// operation codes of an input item
	localparam logic [1:0] OP_ENDPOINT  = 2'd0;
	localparam logic [1:0] OP_LABEL     = 2'd1;
	localparam logic [1:0] OP_NEW_QUERY = 2'd2;
	localparam logic [1:0] OP_NOP       = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_LEFTOVER = 2'd2;

	typedef struct packed {
		logic [6:0] object_count;
		logic [1:0] dimension_count;
		logic       use_sets;
		logic       set_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] endpoint_code;
		logic [5:0] object_index;
		logic [7:0] set_label;
	} req_t;

	typedef struct packed {
		logic        pair_valid;
		logic [6:0]  object_high;
		logic [6:0]  object_low;
		logic [1:0]  status;
		logic        pass_done;
		logic [10:0] pairs_so_far;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		K_OPEN,
		K_CLOSE,
		K_BAD,
		K_LABEL,
		K_CLEAR,
		K_PLAIN
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [OBJ_W-1:0] obj;
		logic [5:0]       object_index;
		logic [7:0]       set_label;
	} item_t;

endpackage

FILE: rtl/core/spp_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on spp_pkg for the payload types it is used with.
interface spp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/spp_front.sv
// Front end: accepts input items, classifies them and queues them for the engine.
// Depends on spp_pkg and spp_if.
module spp_front
	import spp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	spp_if.sink   req,
	input  logic  pop,
	output logic  item_valid,
	output item_t item
);

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      cls;
	logic [7:0] twice_cnt;
	logic [7:0] open_rel;
	logic       push;
	logic       do_pop;

	assign twice_cnt = {cfg.object_count, 1'b0};
	assign open_rel  = req.data.endpoint_code - {1'b0, cfg.object_count} - 8'd1;

	// classify the incoming item
	always_comb begin
		cls.kind         = K_PLAIN;
		cls.obj          = req.data.endpoint_code[OBJ_W-1:0] - 6'd1;
		cls.object_index = req.data.object_index;
		cls.set_label    = req.data.set_label;
		case (req.data.operation)
			OP_LABEL:     cls.kind = K_LABEL;
			OP_NEW_QUERY: cls.kind = K_CLEAR;
			OP_ENDPOINT: begin
				if (req.data.endpoint_code == 8'd0 || req.data.endpoint_code > twice_cnt) begin
					cls.kind = K_BAD;
				end else if (req.data.endpoint_code > {1'b0, cfg.object_count}) begin
					cls.kind = K_OPEN;
					cls.obj  = open_rel[OBJ_W-1:0];
				end else begin
					cls.kind = K_CLOSE;
				end
			end
			default:      cls.kind = K_PLAIN;
		endcase
	end

	assign req.ready  = (count_q != 2'd2);
	assign push       = req.valid && req.ready;
	assign item_valid = (count_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign do_pop     = pop && item_valid;

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

FILE: rtl/core/spp_back.sv
// Back end: open set, pair counters and set labels; executes queued items
// and produces results. Depends on spp_pkg and spp_if.
module spp_back
	import spp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  item_valid,
	input  item_t item,
	output logic  pop,
	spp_if.source rsp
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ONE,
		S_SRD,
		S_SCHK,
		S_PRD,
		S_PDAT,
		S_PCNT,
		S_PEMIT,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [OBJ_W-1:0]    clr_q;
	logic                clr_after_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   ep_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [SIZE_W-1:0]   i_q;
	logic [OBJ_W-1:0]    pos_q;
	logic [OBJ_W-1:0]    obj_q;
	logic [OBJ_W-1:0]    hi_q;
	logic [OBJ_W-1:0]    lo_q;
	logic                hit_q;
	logic                pend_v_q;
	logic [OBJ_W-1:0]    pend_hi_q;
	logic [OBJ_W-1:0]    pend_lo_q;
	logic [1:0]          st_q;
	logic                out_valid_q;
	rsp_t                out_q;

	// memories
	logic [OBJ_W-1:0] ol_mem [MAX_OBJECTS];
	logic [7:0]       lb_mem [MAX_OBJECTS];
	logic [ROW_W-1:0] pm_mem [MAX_OBJECTS];
	logic [OBJ_W-1:0] ol_rd_q;
	logic [7:0]       lb_a_q;
	logic [7:0]       lb_b_q;
	logic [ROW_W-1:0] row_q;

	logic             ol_we, ol_re;
	logic [OBJ_W-1:0] ol_waddr, ol_raddr, ol_wdata;
	logic             lb_we, lb_rea, lb_reb;
	logic [OBJ_W-1:0] lb_waddr, lb_raddr_a, lb_raddr_b;
	logic [7:0]       lb_wdata;
	logic             pm_we, pm_re;
	logic [OBJ_W-1:0] pm_waddr, pm_raddr;
	logic [ROW_W-1:0] pm_wdata;

	logic             out_free;
	logic [1:0]       cnt_cur;
	logic [1:0]       cnt_inc;
	logic [6:0]       cnt_sel;
	logic             filt_ok;
	logic [7:0]       ep_next;
	logic             pass_end;
	logic [OBJ_W-1:0] other_hi, other_lo;
	logic [SIZE_W-1:0] i_dec;

	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign cnt_sel  = {lo_q, 1'b0};
	assign cnt_cur  = row_q[cnt_sel +: 2];
	assign cnt_inc  = cnt_cur + 2'd1;
	assign filt_ok  = !cfg.use_sets || (cfg.set_mode == (lb_a_q == lb_b_q));
	assign ep_next  = {1'b0, ep_q} + 8'd1;
	assign pass_end = ep_next >= {cfg.object_count, 1'b0};
	assign other_hi = (obj_q > ol_rd_q) ? obj_q : ol_rd_q;
	assign other_lo = (obj_q > ol_rd_q) ? ol_rd_q : obj_q;
	assign i_dec    = i_q - 7'd1;

	// memory control
	always_comb begin
		pop        = 1'b0;
		ol_we      = 1'b0;
		ol_re      = 1'b0;
		ol_waddr   = size_q[OBJ_W-1:0];
		ol_raddr   = i_q[OBJ_W-1:0];
		ol_wdata   = item.obj;
		lb_we      = 1'b0;
		lb_rea     = 1'b0;
		lb_reb     = 1'b0;
		lb_waddr   = item.object_index;
		lb_raddr_a = item.obj;
		lb_raddr_b = ol_rd_q;
		lb_wdata   = item.set_label;
		pm_we      = 1'b0;
		pm_re      = 1'b0;
		pm_waddr   = hi_q;
		pm_raddr   = other_hi;
		pm_wdata   = row_q;
		case (state_q)
			S_CLR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
			end
			S_IDLE: begin
				pop = item_valid;
				if (item_valid) begin
					case (item.kind)
						K_LABEL: lb_we = 1'b1;
						K_OPEN:  ol_we = (size_q < SIZE_W'(MAX_OBJECTS));
						K_CLOSE: lb_rea = 1'b1;
						default: ;
					endcase
				end
			end
			S_SRD: ol_re = (i_q != size_q);
			S_PRD: ol_re = (i_q != size_q) && (i_q[OBJ_W-1:0] != pos_q);
			S_PDAT: begin
				ol_we    = (i_q[OBJ_W-1:0] > pos_q);
				ol_waddr = i_dec[OBJ_W-1:0];
				ol_wdata = ol_rd_q;
				pm_re    = 1'b1;
				lb_reb   = 1'b1;
			end
			S_PCNT: begin
				pm_we = (cnt_cur != 2'd3);
				pm_wdata[cnt_sel +: 2] = cnt_inc;
			end
			default: ;
		endcase
	end

	// open list
	always_ff @(posedge clk) begin
		if (ol_we) ol_mem[ol_waddr] <= ol_wdata;
		if (ol_re) ol_rd_q <= ol_mem[ol_raddr];
	end

	// set labels
	always_ff @(posedge clk) begin
		if (lb_we) lb_mem[lb_waddr] <= lb_wdata;
		if (lb_rea) lb_a_q <= lb_mem[lb_raddr_a];
		if (lb_reb) lb_b_q <= lb_mem[lb_raddr_b];
	end

	// pair counters, one row per larger object
	always_ff @(posedge clk) begin
		if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
		if (pm_re) row_q <= pm_mem[pm_raddr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_after_q <= 1'b0;
			size_q      <= '0;
			ep_q        <= '0;
			total_q     <= '0;
			i_q         <= '0;
			pos_q       <= '0;
			obj_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			hit_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_hi_q   <= '0;
			pend_lo_q   <= '0;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'(MAX_OBJECTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						obj_q       <= item.obj;
						st_q        <= ST_OK;
						clr_after_q <= 1'b0;
						i_q         <= '0;
						case (item.kind)
							K_OPEN: begin
								if (size_q < SIZE_W'(MAX_OBJECTS)) size_q <= size_q + 7'd1;
								state_q <= S_FIN;
							end
							K_CLOSE: state_q <= S_SRD;
							K_BAD: begin
								st_q    <= ST_REJECT;
								state_q <= S_ONE;
							end
							K_CLEAR: begin
								size_q      <= '0;
								ep_q        <= '0;
								total_q     <= '0;
								clr_after_q <= 1'b1;
								state_q     <= S_ONE;
							end
							default: state_q <= S_ONE;
						endcase
					end
				end
				S_ONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= '{pair_valid: 1'b0, object_high: 7'd0, object_low: 7'd0,
							status: st_q, pass_done: 1'b0, pairs_so_far: total_q, last: 1'b1};
						clr_q       <= '0;
						state_q     <= clr_after_q ? S_CLR : S_IDLE;
					end
				end
				// search for the earliest entry of the closing object
				S_SRD: begin
					if (i_q == size_q) begin
						st_q    <= ST_REJECT;
						state_q <= S_ONE;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (ol_rd_q == obj_q) begin
						pos_q   <= i_q[OBJ_W-1:0];
						i_q     <= '0;
						state_q <= S_PRD;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_SRD;
					end
				end
				// compact and count pairs with the entries still open
				S_PRD: begin
					if (i_q == size_q) begin
						size_q  <= size_q - 7'd1;
						state_q <= S_FIN;
					end else if (i_q[OBJ_W-1:0] == pos_q) begin
						i_q <= i_q + 7'd1;
					end else begin
						state_q <= S_PDAT;
					end
				end
				S_PDAT: begin
					hi_q    <= other_hi;
					lo_q    <= other_lo;
					state_q <= S_PCNT;
				end
				S_PCNT: begin
					hit_q   <= (cnt_cur != 2'd3) && ({2'b00, cnt_inc} == {2'b00, cfg.dimension_count})
						&& filt_ok;
					state_q <= S_PEMIT;
				end
				S_PEMIT: begin
					if (!hit_q) begin
						i_q     <= i_q + 7'd1;
						state_q <= S_PRD;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{pair_valid: 1'b1,
								object_high: {1'b0, pend_hi_q} + 7'd1,
								object_low: {1'b0, pend_lo_q} + 7'd1,
								status: ST_OK, pass_done: 1'b0, pairs_so_far: total_q,
								last: 1'b0};
						end
						pend_v_q  <= 1'b1;
						pend_hi_q <= hi_q;
						pend_lo_q <= lo_q;
						if (total_q != '1) total_q <= total_q + 11'd1;
						i_q       <= i_q + 7'd1;
						state_q   <= S_PRD;
					end
				end
				// final result and pass bookkeeping
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= '{pair_valid: pend_v_q,
							object_high: pend_v_q ? {1'b0, pend_hi_q} + 7'd1 : 7'd0,
							object_low: pend_v_q ? {1'b0, pend_lo_q} + 7'd1 : 7'd0,
							status: (pass_end && size_q != '0) ? ST_LEFTOVER : ST_OK,
							pass_done: pass_end, pairs_so_far: total_q, last: 1'b1};
						pend_v_q    <= 1'b0;
						if (pass_end) begin
							size_q <= '0;
							ep_q   <= '0;
						end else begin
							ep_q <= ep_next[SIZE_W-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/sweep_prune_pair_finder.sv
// Sweep and prune broad-phase pair finder, top level with configuration registers.
// Depends on spp_pkg, spp_if, spp_front and spp_back.
//
// Items enter on req (valid/ready) and results leave on rsp; each transfer
// moves one item or one result. Every item gives at least one result, the
// final one flagged by last. A close gives one result per reported pair.
// A front end classifies items into a two-entry queue, so req keeps taking
// items while the engine works or rsp is stalled, until the queue is full;
// a stalled rsp holds its result and the engine waits for it.
// A close first searches the open list for the earliest entry of the closing
// object, then visits every other entry to compact the list and count pairs.
// Reset, and every new query, runs a clearing pass over the pair counter rows,
// during which no queued item is executed. Configuration is written through
// cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not
// enforce this. object_count is clamped to 1..64, a dimension_count of 0 reads as 1.
module sweep_prune_pair_finder
	import spp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	spp_if.sink        req,
	spp_if.source      rsp
);

	cfg_t  cfg_q;
	logic  pop;
	logic  item_valid;
	item_t item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{object_count: 7'd64, dimension_count: 2'd2, use_sets: 1'b0,
				set_mode: 1'b0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBJECT_COUNT: begin
					if (cfg_data == 7'd0) cfg_q.object_count <= 7'd1;
					else if (cfg_data > 7'(MAX_OBJECTS)) cfg_q.object_count <= 7'(MAX_OBJECTS);
					else cfg_q.object_count <= cfg_data;
				end
				REG_DIMENSION_COUNT: begin
					cfg_q.dimension_count <= (cfg_data[1:0] == 2'd0) ? 2'd1 : cfg_data[1:0];
				end
				REG_USE_SETS: cfg_q.use_sets <= cfg_data[0];
				REG_SET_MODE: cfg_q.set_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	spp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	spp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

FILE: tb/spp_pair_checker.sv
// Result checker for the sweep and prune pair finder: tracks configuration writes,
// predicts the results of each accepted item and compares every result transfer.
// Depends on spp_pkg and the spp_if channel interface.
`timescale 1ns / 100ps

module spp_pair_checker
	import spp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	spp_if             req,
	spp_if             rsp,
	output int         errors,
	output int         pending
);

	// shadow registers and sweep state
	int   obj_count;
	int   dim_count;
	bit   use_sets;
	bit   set_mode;
	int   open_objs[$];
	bit [1:0] overlap_cnt [MAX_OBJECTS][MAX_OBJECTS];
	bit [7:0] labels [MAX_OBJECTS];
	int   ep_count;
	int   pass_no;
	int   pair_sum;
	rsp_t pair_q[$];

	assign pending = pair_q.size();

	task automatic clear_sweep();
		open_objs.delete();
		foreach (overlap_cnt[i, j]) overlap_cnt[i][j] = 2'd0;
		ep_count = 0;
		pass_no  = 0;
		pair_sum = 0;
	endtask

	// apply one register write, with the same clamping as the block
	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		case (idx)
			REG_OBJECT_COUNT: begin
				obj_count = (val == 0) ? 1 : (val > MAX_OBJECTS) ? MAX_OBJECTS : int'(val);
			end
			REG_DIMENSION_COUNT: begin
				dim_count = (val[1:0] == 0) ? 1 : int'(val[1:0]);
			end
			REG_USE_SETS: use_sets = val[0];
			REG_SET_MODE: set_mode = val[0];
			default: ;
		endcase
	endtask

	// work out the results of one accepted item and queue them
	task automatic predict_pairs(req_t r);
		rsp_t outs[$];
		rsp_t one;
		int   code;
		int   obj;
		int   pos;
		int   hi;
		int   lo;
		bit   same;
		bit   done;
		logic [1:0] st;
		code = int'(r.endpoint_code);
		done = 1'b0;
		st   = ST_OK;
		one  = '0;
		if (r.operation == OP_LABEL) labels[r.object_index] = r.set_label;
		if (r.operation == OP_NEW_QUERY) clear_sweep();
		if (r.operation != OP_ENDPOINT) begin
			one.pairs_so_far = 11'(pair_sum);
			one.last = 1'b1;
			pair_q.push_back(one);
			return;
		end
		if (code == 0 || code > 2 * obj_count) begin
			one.status = ST_REJECT;
			one.pairs_so_far = 11'(pair_sum);
			one.last = 1'b1;
			pair_q.push_back(one);
			return;
		end
		if (code > obj_count) begin
			if (open_objs.size() < MAX_OBJECTS) open_objs.push_back(code - obj_count - 1);
		end else begin
			obj = code - 1;
			pos = -1;
			foreach (open_objs[i]) if (pos < 0 && open_objs[i] == obj) pos = i;
			if (pos < 0) begin
				one.status = ST_REJECT;
				one.pairs_so_far = 11'(pair_sum);
				one.last = 1'b1;
				pair_q.push_back(one);
				return;
			end
			open_objs.delete(pos);
			foreach (open_objs[i]) begin
				hi = (obj > open_objs[i]) ? obj : open_objs[i];
				lo = (obj > open_objs[i]) ? open_objs[i] : obj;
				if (overlap_cnt[hi][lo] != 2'd3) begin
					overlap_cnt[hi][lo]++;
					same = (labels[hi] == labels[lo]);
					if (overlap_cnt[hi][lo] == dim_count && (!use_sets || same == set_mode)) begin
						if (pair_sum < 2047) pair_sum++;
						one = '0;
						one.pair_valid   = 1'b1;
						one.object_high  = 7'(hi + 1);
						one.object_low   = 7'(lo + 1);
						one.pairs_so_far = 11'(pair_sum);
						outs.push_back(one);
					end
				end
			end
		end
		// pass end bookkeeping
		if (ep_count + 1 >= 2 * obj_count) begin
			done = 1'b1;
			if (open_objs.size() != 0) st = ST_LEFTOVER;
			open_objs.delete();
			ep_count = 0;
			if (pass_no < 3) pass_no++;
		end else begin
			ep_count++;
		end
		if (outs.size() == 0) begin
			one = '0;
			one.pairs_so_far = 11'(pair_sum);
			outs.push_back(one);
		end
		outs[$].status    = st;
		outs[$].pass_done = done;
		outs[$].last      = 1'b1;
		foreach (outs[i]) pair_q.push_back(outs[i]);
	endtask

	initial begin
		errors    = 0;
		obj_count = MAX_OBJECTS;
		dim_count = 2;
		use_sets  = 0;
		set_mode  = 0;
		foreach (labels[i]) labels[i] = 8'd0;
		clear_sweep();
	end

	// sample in mid-cycle: everything is settled before the next rising edge
	always @(negedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n) begin
			if (cfg_we) write_reg(cfg_index, cfg_data);
			if (req.valid && req.ready) predict_pairs(req.data);
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (pair_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors++;
				end else begin
					want = pair_q.pop_front();
					if (got.pair_valid !== want.pair_valid || got.object_high !== want.object_high
						|| got.object_low !== want.object_low || got.status !== want.status
						|| got.pass_done !== want.pass_done
						|| got.pairs_so_far !== want.pairs_so_far || got.last !== want.last) begin
						$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
						errors++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top for the sweep and prune pair finder: clock, reset, stimulus and verdict.
// Depends on spp_pkg, spp_if, the block itself and spp_pair_checker.
`timescale 1ns / 100ps

module tb;
	import spp_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [1:0] cfg_index = REG_OBJECT_COUNT;
	logic [6:0] cfg_data = '0;
	int         errors;
	int         pending;
	int         cycles = 0;
	int         sent = 0;
	int         cur_count = MAX_OBJECTS;
	bit         calm = 0;

	spp_if #(.T(req_t)) req ();
	spp_if #(.T(rsp_t)) rsp ();

	sweep_prune_pair_finder dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	spp_pair_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .errors(errors), .pending(pending)
	);

	always #6 clk = ~clk;

	initial begin
		req.valid = 0;
		req.data  = '0;
		rsp.ready = 0;
	end

	// result side stalls at random outside the calm stretch
	always @(posedge clk) rsp.ready <= calm || ($urandom_range(99) >= 28);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one item transfer, with random gaps before it
	task automatic send(logic [1:0] op, int code, int idx, int lab);
		bit hit;
		while (!calm && $urandom_range(99) < 28) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.data  <= '{operation: op, endpoint_code: code[7:0], object_index: idx[5:0],
			set_label: lab[7:0]};
		do begin
			@(negedge clk);
			hit = req.ready;
			@(posedge clk);
		end while (!hit);
		sent++;
	endtask

	task automatic endpoint(int code);
		send(OP_ENDPOINT, code, $urandom_range(63), $urandom_range(255));
	endtask

	// drain, then let the engine settle
	task automatic quiet();
		req.valid <= 0;
		wait (pending == 0);
		repeat (450) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, int val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val[6:0];
		@(posedge clk);
		cfg_we    <= 0;
		@(posedge clk);
		if (idx == REG_OBJECT_COUNT) cur_count = (val == 0) ? 1 : (val > 64) ? 64 : val;
	endtask

	// noise item: reject codes, stray endpoints, no-ops and label writes
	task automatic noise();
		case ($urandom_range(4))
			0: endpoint(0);
			1: endpoint($urandom_range(255, 2 * cur_count + 1));
			2: endpoint($urandom_range(2 * cur_count, 1));
			3: send(OP_NOP, $urandom_range(255), $urandom_range(63), $urandom_range(255));
			default: send(OP_LABEL, $urandom_range(255), $urandom_range(63), $urandom_range(255));
		endcase
	endtask

	// one well-formed pass: each object opens before it closes, order shuffled
	task automatic sweep_pass(int n, int noise_pct);
		int toks[$];
		int seen[64];
		foreach (seen[i]) seen[i] = 0;
		for (int i = 0; i < n; i++) begin
			toks.push_back(i);
			toks.push_back(i);
		end
		toks.shuffle();
		foreach (toks[i]) begin
			if ($urandom_range(99) < noise_pct) noise();
			if (seen[toks[i]] == 0) endpoint(toks[i] + 1 + n);
			else endpoint(toks[i] + 1);
			seen[toks[i]]++;
		end
	endtask

	initial begin
		int n;
		int dims;
		int q;
		int passes;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// label setup so that every label read sees a written value
		calm = 1;
		for (int i = 0; i < 64; i++) send(OP_LABEL, 1, i, $urandom_range(3));
		calm = 0;

		// directed: two objects, one dimension
		quiet();
		cfg_write(REG_OBJECT_COUNT, 2);
		cfg_write(REG_DIMENSION_COUNT, 0);
		send(OP_NEW_QUERY, 0, 0, 0);
		endpoint(3); endpoint(4); endpoint(1); endpoint(2);     // one overlapping pair
		endpoint(0); endpoint(5); endpoint(255); endpoint(1);   // rejects, close of closed
		send(OP_NOP, 128, 63, 255);
		endpoint(3); endpoint(3); endpoint(1); endpoint(4);     // duplicate open, leftover
		endpoint(4); endpoint(4); endpoint(2); endpoint(2);     // pair of an object with itself
		send(OP_LABEL, 255, 63, 0);
		send(OP_LABEL, 0, 0, 255);

		// random queries; the second one overfills the open set
		q = 0;
		while (sent < 200) begin
			quiet();
			calm = (q >= 3 && q < 5);
			case ($urandom_range(9))
				0, 1: n = $urandom_range(9, 7);
				default: n = $urandom_range(6, 1);
			endcase
			if (q == 1) n = 64;
			dims = $urandom_range(3);
			if ($urandom_range(5) == 0) cfg_write(REG_OBJECT_COUNT, (n == 64) ? 127 : n);
			else cfg_write(REG_OBJECT_COUNT, n);
			if (n == 1 && $urandom_range(1)) cfg_write(REG_OBJECT_COUNT, 0);
			cfg_write(REG_DIMENSION_COUNT, dims);
			cfg_write(REG_USE_SETS, $urandom_range(1));
			cfg_write(REG_SET_MODE, $urandom_range(1));
			if (dims == 0) dims = 1;
			send(OP_NEW_QUERY, $urandom_range(255), $urandom_range(63), $urandom_range(255));
			if (q == 1) begin
				// overfill the open set, then close a few objects
				for (int i = 0; i < 66; i++) endpoint($urandom_range(128, 65));
				for (int i = 0; i < 8; i++) endpoint($urandom_range(64, 1));
			end else begin
				passes = dims;
				for (int p = 0; p < passes; p++) sweep_pass(n, 12);
			end
			q++;
		end
		calm = 0;
		quiet();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
